>>> hw/rtl/per_queue_dispatch_window_sync_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-queue dispatch window synchronizer
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PER_QUEUE_DISPATCH_WINDOW_SYNC_MACROS_SVH
`define PER_QUEUE_DISPATCH_WINDOW_SYNC_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PQDWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PQDWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/pqdws_pkg.sv
// ----------------------------------------------------------------------------
// pqdws_pkg
// Types and constants shared by the dispatch window synchronizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pqdws_pkg;

    localparam int QID_W   = 32;
    localparam int WIN_W   = 11;
    localparam int PHASE_W = 10;
    localparam int CNT_W   = 64;
    localparam int NS_W    = 64;

    localparam logic [WIN_W-1:0] WINDOW_LIMIT = 11'd1024;

    typedef enum logic [1:0] {
        OP_DISPATCH  = 2'd0,
        OP_WAIT_DONE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_RSVD      = 2'd3
    } opcode_t;

    typedef enum logic [0:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_COUNTING_EN = 1'b1
    } cfg_index_t;

    // search word walking down the table
    typedef struct packed {
        logic               go;
        logic               hit;
        logic               free;
        logic [PHASE_W-1:0] phase;
    } srch_t;

    // table write command broadcast to every cell
    typedef struct packed {
        logic               clr;
        logic               wr;
        logic               fresh;
        logic [PHASE_W-1:0] phase;
    } upd_t;

endpackage

`default_nettype wire

>>> hw/rtl/pqdws_if.sv
// ----------------------------------------------------------------------------
// pqdws_in_if / pqdws_out_if
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pqdws_in_if
    import pqdws_pkg::*;
();
    logic                valid;
    logic                ready;
    opcode_t             opcode;
    logic [QID_W-1:0]    queue_id;
    logic [NS_W-1:0]     wait_ns;

    modport source (output valid, opcode, queue_id, wait_ns, input ready);
    modport sink   (input valid, opcode, queue_id, wait_ns, output ready);
endinterface

interface pqdws_out_if
    import pqdws_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                wait_now;
    logic [CNT_W-1:0]    dispatches_seen;
    logic [CNT_W-1:0]    waits_seen;
    logic [CNT_W-1:0]    wait_time_total;
    logic [CNT_W-1:0]    wait_time_max;

    modport source (output valid, wait_now, dispatches_seen, waits_seen, wait_time_total,
                    wait_time_max, input ready);
    modport sink   (input valid, wait_now, dispatches_seen, waits_seen, wait_time_total,
                    wait_time_max, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pqdws_cell.sv
// ----------------------------------------------------------------------------
// pqdws_cell
// One table entry plus one stage of the lookup chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pqdws_cell
    import pqdws_pkg::*;
#(
    parameter int KEY_W    = 32,
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic             sel,
    input  wire upd_t             upd,
    input  wire srch_t            srch_in,
    input  wire logic [IDX_W-1:0] hit_idx_in,
    input  wire logic [IDX_W-1:0] free_idx_in,
    output srch_t                 srch_out,
    output logic [IDX_W-1:0]      hit_idx_out,
    output logic [IDX_W-1:0]      free_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic               valid_reg;
    logic [KEY_W-1:0]   queue_reg;
    logic [PHASE_W-1:0] phase_reg;

    srch_t              srch_reg, srch_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    // first hit wins; otherwise remember the first empty entry
    always_comb
    begin
        srch_next     = srch_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (srch_in.go && !srch_in.hit)
        begin
            if (valid_reg && (queue_reg == key))
            begin
                srch_next.hit   = 1'b1;
                srch_next.phase = phase_reg;
                hit_idx_next    = MY_IDX;
            end
            else if (!valid_reg && !srch_in.free)
            begin
                srch_next.free = 1'b1;
                free_idx_next  = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            srch_reg <= srch_next;
            if (upd.clr)
            begin
                valid_reg <= 1'b0;
            end
            else if (sel && upd.wr)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        if (sel && upd.wr)
        begin
            if (upd.fresh)
            begin
                queue_reg <= key;
            end
            phase_reg <= upd.phase;
        end
    end

    assign srch_out     = srch_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

`default_nettype wire

>>> hw/rtl/per_queue_dispatch_window_sync.sv
// ----------------------------------------------------------------------------
// per_queue_dispatch_window_sync
// Counts dispatches per command queue and flags when a wait is due.
// ----------------------------------------------------------------------------
// One event word is taken at a time. A counted dispatch walks a search word
// down a chain of TABLE_ENTRIES cells, one cell per cycle, then writes the
// chosen entry before its result word is loaded; wait-done, clear, unused
// opcodes and uncounted dispatches skip the chain. A result word is loaded
// into the output register only once that register is empty or being taken
// by the sink. The next event word can be accepted as soon as the current
// result sits in the output register, even if the sink has not taken it yet.
// Configuration writes are only allowed while no event is in flight.
`default_nettype none

module per_queue_dispatch_window_sync
    import pqdws_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int QUEUE_ID_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire cfg_index_t       cfg_index,
    input  wire logic [WIN_W-1:0] cfg_data,
    pqdws_in_if.sink              cmd,
    pqdws_out_if.source           rsp
);

    localparam int KEY_W = (QUEUE_ID_BITS < QID_W) ? QUEUE_ID_BITS : QID_W;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SRCH = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [WIN_W-1:0] win_reg;
    logic             cnt_en_reg;
    logic             active;

    // latched event word
    opcode_t          op_reg;
    logic [KEY_W-1:0] qid_reg;
    logic [NS_W-1:0]  ns_reg;

    // counters
    logic [CNT_W-1:0] disp_reg, waits_reg, sum_reg, peak_reg;
    logic             wait_now_reg;

    // result word
    logic             rsp_valid_reg;
    logic             rsp_wait_now_reg;
    logic [CNT_W-1:0] rsp_disp_reg, rsp_waits_reg, rsp_sum_reg, rsp_peak_reg;

    // lookup chain
    srch_t            chain_srch [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] chain_hit  [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] chain_free [TABLE_ENTRIES+1];
    srch_t            end_srch;
    logic [TABLE_ENTRIES-1:0] sel;
    upd_t             upd;
    logic [IDX_W-1:0] slot;
    logic [PHASE_W-1:0] cur_phase;
    logic [WIN_W-1:0] phase_inc;
    logic             wrap;
    logic             start;
    logic             out_free;

    assign active   = cnt_en_reg && (win_reg != '0) && (win_reg <= WINDOW_LIMIT);
    assign start    = (state_reg == S_EXEC) && (op_reg == OP_DISPATCH) && active;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign chain_srch[0] = '{go: start, hit: 1'b0, free: 1'b0, phase: '0};
    assign chain_hit[0]  = '0;
    assign chain_free[0] = '0;

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++)
    begin : g_cell
        assign sel[gi] = (slot == IDX_W'(gi));

        pqdws_cell #(
            .KEY_W    (KEY_W),
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .key          (qid_reg),
            .sel          (sel[gi]),
            .upd          (upd),
            .srch_in      (chain_srch[gi]),
            .hit_idx_in   (chain_hit[gi]),
            .free_idx_in  (chain_free[gi]),
            .srch_out     (chain_srch[gi+1]),
            .hit_idx_out  (chain_hit[gi+1]),
            .free_idx_out (chain_free[gi+1])
        );
    end

    // resolve the walk: hit, else first empty entry, else entry 0
    always_comb
    begin
        end_srch  = chain_srch[TABLE_ENTRIES];
        if (end_srch.hit)
        begin
            slot = chain_hit[TABLE_ENTRIES];
        end
        else if (end_srch.free)
        begin
            slot = chain_free[TABLE_ENTRIES];
        end
        else
        begin
            slot = '0;
        end
        cur_phase = end_srch.hit ? end_srch.phase : '0;
        phase_inc = {1'b0, cur_phase} + WIN_W'(1);
        // >= also catches a phase left over from a larger window
        wrap      = (phase_inc >= win_reg);

        upd.clr   = (state_reg == S_EXEC) && (op_reg == OP_CLEAR);
        upd.wr    = (state_reg == S_SRCH) && end_srch.go;
        upd.fresh = !end_srch.hit;
        upd.phase = wrap ? '0 : phase_inc[PHASE_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = start ? S_SRCH : S_RESP;
            end
            S_SRCH:
            begin
                if (end_srch.go)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            win_reg    <= '0;
            cnt_en_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_SIZE: win_reg    <= cfg_data;
                    CFG_COUNTING_EN: cnt_en_reg <= cfg_data[0];
                    default:         cnt_en_reg <= cnt_en_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg  <= cmd.opcode;
            qid_reg <= cmd.queue_id[KEY_W-1:0];
            ns_reg  <= cmd.wait_ns;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg     <= '0;
            waits_reg    <= '0;
            sum_reg      <= '0;
            peak_reg     <= '0;
            wait_now_reg <= 1'b0;
        end
        else if (state_reg == S_EXEC)
        begin
            wait_now_reg <= 1'b0;
            unique case (op_reg)
                OP_DISPATCH:
                begin
                    if (active)
                    begin
                        disp_reg <= disp_reg + CNT_W'(1);
                    end
                end
                OP_WAIT_DONE:
                begin
                    waits_reg <= waits_reg + CNT_W'(1);
                    sum_reg   <= sum_reg + ns_reg;
                    if (ns_reg > peak_reg)
                    begin
                        peak_reg <= ns_reg;
                    end
                end
                OP_CLEAR:
                begin
                    disp_reg  <= '0;
                    waits_reg <= '0;
                    sum_reg   <= '0;
                    peak_reg  <= '0;
                end
                default:
                begin
                    peak_reg <= peak_reg;
                end
            endcase
        end
        else if (upd.wr)
        begin
            wait_now_reg <= wrap;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_RESP) && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RESP) && out_free)
        begin
            rsp_wait_now_reg <= wait_now_reg;
            rsp_disp_reg     <= disp_reg;
            rsp_waits_reg    <= waits_reg;
            rsp_sum_reg      <= sum_reg;
            rsp_peak_reg     <= peak_reg;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.wait_now        = rsp_wait_now_reg;
    assign rsp.dispatches_seen = rsp_disp_reg;
    assign rsp.waits_seen      = rsp_waits_reg;
    assign rsp.wait_time_total = rsp_sum_reg;
    assign rsp.wait_time_max   = rsp_peak_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pqdws_chk.sv
// ----------------------------------------------------------------------------
// pqdws_chk
// Port-level checks for the dispatch window synchronizer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_queue_dispatch_window_sync_macros.svh"

module pqdws_chk
    import pqdws_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             cmd_valid,
    input wire logic             cmd_ready,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic             rsp_wait_now,
    input wire logic [CNT_W-1:0] rsp_dispatches_seen,
    input wire logic [CNT_W-1:0] rsp_waits_seen,
    input wire logic [CNT_W-1:0] rsp_wait_time_total,
    input wire logic [CNT_W-1:0] rsp_wait_time_max
);

    // a stalled result word holds
    `PQDWS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_wait_now) && $stable(rsp_dispatches_seen) && $stable(rsp_waits_seen) && $stable(rsp_wait_time_total) && $stable(rsp_wait_time_max))

    // one event in flight at a time
    `PQDWS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // a forced wait only comes from a counted dispatch
    `PQDWS_ASSERT_NOW(a_wait_counted, clk, rst_n, rsp_valid && rsp_wait_now, rsp_dispatches_seen != '0)

endmodule

bind per_queue_dispatch_window_sync pqdws_chk u_pqdws_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_wait_now        (rsp.wait_now),
    .rsp_dispatches_seen (rsp.dispatches_seen),
    .rsp_waits_seen      (rsp.waits_seen),
    .rsp_wait_time_total (rsp.wait_time_total),
    .rsp_wait_time_max   (rsp.wait_time_max)
);

`default_nettype wire
